@@ rtl/phdc_pkg.sv @@
// phdc_pkg: shared types and constants for the pursuit head distance chain
// used by phdc_ctrl, phdc_dpath and pursuit_head_distance_chain_top
`timescale 1ns / 1ps
`default_nettype none

package phdc_pkg;

    // field widths
    localparam int PTR_W   = 12;
    localparam int POS_W   = 16;
    localparam int PART_W  = 4;
    localparam int STEP_W  = 10;
    localparam int HALO_W  = 12;
    localparam int SPACE_W = 12;
    localparam int THR_W   = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEAD_STEP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEAD_HALO    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINK_SPACING = 2'd2;

    // reset values
    localparam logic [STEP_W-1:0]  RST_HEAD_STEP    = 10'd80;
    localparam logic [HALO_W-1:0]  RST_HEAD_HALO    = 12'd544;
    localparam logic [SPACE_W-1:0] RST_LINK_SPACING = 12'd640;
    localparam logic signed [POS_W-1:0] RST_POS     = -16'sd2400;

    localparam logic signed [POS_W-1:0] POS_MAX = 16'sh7FFF;
    localparam logic signed [POS_W-1:0] POS_MIN = -16'sh8000;

    // controller states
    typedef enum logic [4:0] {
        S_IDLE,
        S_HEAD,
        S_RD,
        S_LOAD,
        S_DIFF,
        S_SQX,
        S_SQY,
        S_SUM,
        S_CMP,
        S_SQRT_INIT,
        S_SQRT,
        S_OVER,
        S_MUL,
        S_NUM,
        S_DIV,
        S_ADD,
        S_STORE,
        S_EMIT
    } t_state;

    // datapath operations
    typedef enum logic [4:0] {
        DP_NOP,
        DP_ACCEPT,
        DP_LOAD_HEAD,
        DP_MEM_RD,
        DP_LOAD_LINK,
        DP_DIFF,
        DP_SQ,
        DP_SUM,
        DP_HALT,
        DP_SQRT_INIT,
        DP_SQRT_STEP,
        DP_OVER,
        DP_MUL,
        DP_NUM,
        DP_DIV_STEP,
        DP_ADD,
        DP_STORE,
        DP_EMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   axis;   // 0 x, 1 y
        logic   head;   // working on the head
        logic   last;   // final result of the tick
    } t_dp_cmd;

    typedef struct packed {
        logic paused;
        logic head_move;
        logic link_move;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

@@ rtl/pursuit_head_distance_chain_top.sv @@
// Each request (pointer position and pause toggle) produces NUM_LINKS + 1 results: the
// head first, then every link in order, the last one flagged. A part that has to move
// runs the bit-serial square root (17 steps) and then the bit-serial divider once per
// axis (36 steps) at FRAC_BITS = 4; a part that stays skips both, and a paused tick
// skips the distance test too. Output stalls hold the tick. One request at a time.
// Link positions live in a small memory with per-entry valid bits, so no clearing pass.
// top level; uses phdc_pkg, phdc_ctrl and phdc_dpath
`timescale 1ns / 1ps
`default_nettype none

module pursuit_head_distance_chain_top #(
    parameter int NUM_LINKS = 13,
    parameter int FRAC_BITS = 4
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_wr_en,
    input  wire [phdc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire [phdc_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  wire                                  i_in_valid,
    output logic                                 o_in_ready,
    input  wire signed [phdc_pkg::PTR_W-1:0]     i_pointer_x,
    input  wire signed [phdc_pkg::PTR_W-1:0]     i_pointer_y,
    input  wire                                  i_pause_toggle,
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output logic [phdc_pkg::PART_W-1:0]          o_part_index,
    output logic signed [phdc_pkg::POS_W-1:0]    o_pos_x,
    output logic signed [phdc_pkg::POS_W-1:0]    o_pos_y,
    output logic                                 o_is_paused,
    output logic                                 o_last_part
);

    localparam int TW = phdc_pkg::PTR_W + FRAC_BITS;
    localparam int BW = (TW > phdc_pkg::POS_W) ? TW : phdc_pkg::POS_W;
    localparam int DW = BW + 1;
    localparam int RW = DW;
    localparam int NW = RW + DW + 2;
    localparam int AW = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1;

    phdc_pkg::t_dp_cmd           w_cmd;
    phdc_pkg::t_dp_stat          w_stat;
    logic [AW-1:0]               w_link_addr;
    logic [phdc_pkg::PART_W-1:0] w_part;

    // sequencer
    phdc_ctrl #(
        .NUM_LINKS  (NUM_LINKS),
        .SQRT_STEPS (RW),
        .DIV_STEPS  (NW),
        .AW         (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_link_addr (w_link_addr),
        .o_part      (w_part)
    );

    // arithmetic and storage
    phdc_dpath #(
        .NUM_LINKS (NUM_LINKS),
        .FRAC_BITS (FRAC_BITS),
        .AW        (AW)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_pointer_x    (i_pointer_x),
        .i_pointer_y    (i_pointer_y),
        .i_pause_toggle (i_pause_toggle),
        .i_cmd          (w_cmd),
        .i_link_addr    (w_link_addr),
        .i_part         (w_part),
        .o_stat         (w_stat),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_part_index   (o_part_index),
        .o_pos_x        (o_pos_x),
        .o_pos_y        (o_pos_y),
        .o_is_paused    (o_is_paused),
        .o_last_part    (o_last_part)
    );

endmodule

`default_nettype wire

@@ rtl/phdc_dpath.sv @@
// phdc_dpath: datapath with config registers, link store, squarer, serial
// square root, serial divider and output register; uses phdc_pkg
`timescale 1ns / 1ps
`default_nettype none

module phdc_dpath #(
    parameter int NUM_LINKS = 13,
    parameter int FRAC_BITS = 4,
    parameter int AW        = 4
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_cfg_wr_en,
    input  wire [phdc_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  wire [phdc_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    input  wire signed [phdc_pkg::PTR_W-1:0]       i_pointer_x,
    input  wire signed [phdc_pkg::PTR_W-1:0]       i_pointer_y,
    input  wire                                    i_pause_toggle,
    input  wire phdc_pkg::t_dp_cmd                 i_cmd,
    input  wire [AW-1:0]                           i_link_addr,
    input  wire [phdc_pkg::PART_W-1:0]             i_part,
    output phdc_pkg::t_dp_stat                     o_stat,
    output logic                                   o_out_valid,
    input  wire                                    i_out_ready,
    output logic [phdc_pkg::PART_W-1:0]            o_part_index,
    output logic signed [phdc_pkg::POS_W-1:0]      o_pos_x,
    output logic signed [phdc_pkg::POS_W-1:0]      o_pos_y,
    output logic                                   o_is_paused,
    output logic                                   o_last_part
);

    localparam int PW  = phdc_pkg::POS_W;
    localparam int TW  = phdc_pkg::PTR_W + FRAC_BITS;
    localparam int BW  = (TW > PW) ? TW : PW;
    localparam int DW  = BW + 1;
    localparam int SW  = 2 * DW;
    localparam int RW  = DW;
    localparam int FW  = RW;
    localparam int NW  = FW + DW + 2;
    localparam int QW  = RW + 1;
    localparam int AD  = QW + 2;

    // config registers
    logic [phdc_pkg::STEP_W-1:0]  r_step;
    logic [phdc_pkg::HALO_W-1:0]  r_halo;
    logic [phdc_pkg::SPACE_W-1:0] r_spacing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= phdc_pkg::RST_HEAD_STEP;
            r_halo    <= phdc_pkg::RST_HEAD_HALO;
            r_spacing <= phdc_pkg::RST_LINK_SPACING;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                phdc_pkg::REG_HEAD_STEP:    r_step    <= i_cfg_data[phdc_pkg::STEP_W-1:0];
                phdc_pkg::REG_HEAD_HALO:    r_halo    <= i_cfg_data[phdc_pkg::HALO_W-1:0];
                phdc_pkg::REG_LINK_SPACING: r_spacing <= i_cfg_data[phdc_pkg::SPACE_W-1:0];
                default: ;
            endcase
        end
    end

    // working registers
    logic signed [TW-1:0] r_ptx, r_pty;
    logic                 r_paused, r_halted;
    logic signed [PW-1:0] r_hx, r_hy, r_ax, r_ay, r_prx, r_pry;
    logic signed [BW-1:0] r_bx, r_by;
    logic signed [DW-1:0] r_ex, r_ey;
    logic [SW-1:0]        r_sqx, r_sqy, r_d2, r_lim1, r_lim2;
    logic [SW-1:0]        r_rad;
    logic [RW:0]          r_rem;
    logic [RW-1:0]        r_root;
    logic [FW-1:0]        r_factor;
    logic [FW+DW-1:0]     r_prod;
    logic [NW-1:0]        r_num;
    logic [RW:0]          r_drem;

    // link store
    logic [2*PW-1:0]      r_mem [NUM_LINKS];
    logic [NUM_LINKS-1:0] r_mvalid_bits;
    logic [2*PW-1:0]      r_mdata;
    logic                 r_mvalid;

    // magnitudes and multipliers
    logic [DW-1:0]        w_mx, w_my, w_msel;
    logic [SW-1:0]        w_sq;
    logic [FW+DW-1:0]     w_pr;
    logic [SW-1:0]        w_lim_step, w_lim_space, w_lim_thr;
    logic [phdc_pkg::THR_W-1:0] w_thr;
    logic                 w_gt1, w_gt2, w_head_move;

    assign w_mx   = r_ex[DW-1] ? $unsigned(-r_ex) : $unsigned(r_ex);
    assign w_my   = r_ey[DW-1] ? $unsigned(-r_ey) : $unsigned(r_ey);
    assign w_msel = i_cmd.axis ? w_my : w_mx;
    assign w_sq   = SW'(w_msel) * SW'(w_msel);
    assign w_pr   = (FW+DW)'(r_factor) * (FW+DW)'(w_msel);

    // threshold squares, compared against registered d2
    assign w_thr       = phdc_pkg::THR_W'(r_step) + phdc_pkg::THR_W'(r_halo);
    assign w_lim_step  = SW'(r_step) * SW'(r_step);
    assign w_lim_space = SW'(r_spacing) * SW'(r_spacing);
    assign w_lim_thr   = SW'(w_thr) * SW'(w_thr);
    assign w_gt1       = r_d2 > r_lim1;
    assign w_gt2       = r_d2 > r_lim2;
    assign w_head_move = !r_halted && w_gt1;

    // square root step
    logic [RW+2:0] w_sq_trial, w_sq_sub;
    logic          w_sq_ok;
    assign w_sq_trial = {r_rem, r_rad[SW-1 -: 2]};
    assign w_sq_sub   = {1'b0, r_root, 2'b01};
    assign w_sq_ok    = w_sq_trial >= w_sq_sub;

    // divide step, divisor is twice the distance
    logic [RW+1:0] w_dv_trial, w_dv_div;
    logic          w_dv_ok;
    assign w_dv_trial = {r_drem, r_num[NW-1]};
    assign w_dv_div   = {1'b0, r_root, 1'b0};
    assign w_dv_ok    = w_dv_trial >= w_dv_div;

    // signed move and saturation
    logic signed [AD-1:0] w_base, w_q, w_sum;
    logic signed [PW-1:0] w_sat;
    assign w_base = i_cmd.axis ? AD'(r_ay) : AD'(r_ax);
    assign w_q    = $signed(AD'(r_num[QW-1:0]));
    assign w_sum  = (i_cmd.axis ? r_ey[DW-1] : r_ex[DW-1]) ? (w_base - w_q) : (w_base + w_q);
    always_comb begin
        if (w_sum > AD'(phdc_pkg::POS_MAX)) begin
            w_sat = phdc_pkg::POS_MAX;
        end else if (w_sum < AD'(phdc_pkg::POS_MIN)) begin
            w_sat = phdc_pkg::POS_MIN;
        end else begin
            w_sat = w_sum[PW-1:0];
        end
    end

    // control state of the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_paused <= 1'b0;
            r_halted <= 1'b0;
            r_hx     <= phdc_pkg::RST_POS;
            r_hy     <= phdc_pkg::RST_POS;
            r_mvalid_bits <= '0;
        end else begin
            if (i_cmd.op == phdc_pkg::DP_ACCEPT && i_pause_toggle) begin
                r_paused <= !r_paused;
            end
            if (i_cmd.op == phdc_pkg::DP_HALT) begin
                r_halted <= w_head_move ? 1'b0 : !w_gt2;
            end
            if (i_cmd.op == phdc_pkg::DP_STORE) begin
                if (i_cmd.head) begin
                    r_hx <= r_ax;
                    r_hy <= r_ay;
                end else begin
                    r_mvalid_bits[i_link_addr] <= 1'b1;
                end
            end
        end
    end

    // link memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == phdc_pkg::DP_STORE && !i_cmd.head) begin
            r_mem[i_link_addr] <= {r_ax, r_ay};
        end
        if (i_cmd.op == phdc_pkg::DP_MEM_RD) begin
            r_mdata  <= r_mem[i_link_addr];
            r_mvalid <= r_mvalid_bits[i_link_addr];
        end
    end

    // arithmetic payload registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            phdc_pkg::DP_ACCEPT: begin
                r_ptx <= $signed(TW'(i_pointer_x)) <<< FRAC_BITS;
                r_pty <= $signed(TW'(i_pointer_y)) <<< FRAC_BITS;
            end
            phdc_pkg::DP_LOAD_HEAD: begin
                r_ax <= r_hx;
                r_ay <= r_hy;
                r_bx <= BW'(r_ptx);
                r_by <= BW'(r_pty);
            end
            phdc_pkg::DP_LOAD_LINK: begin
                r_ax <= r_mvalid ? $signed(r_mdata[2*PW-1:PW]) : phdc_pkg::RST_POS;
                r_ay <= r_mvalid ? $signed(r_mdata[PW-1:0]) : phdc_pkg::RST_POS;
                r_bx <= BW'(r_prx);
                r_by <= BW'(r_pry);
            end
            phdc_pkg::DP_DIFF: begin
                r_ex <= DW'(r_bx) - DW'(r_ax);
                r_ey <= DW'(r_by) - DW'(r_ay);
            end
            phdc_pkg::DP_SQ: begin
                if (i_cmd.axis) begin
                    r_sqy <= w_sq;
                end else begin
                    r_sqx <= w_sq;
                end
            end
            phdc_pkg::DP_SUM: begin
                r_d2   <= r_sqx + r_sqy;
                r_lim1 <= i_cmd.head ? w_lim_step : w_lim_space;
                r_lim2 <= w_lim_thr;
            end
            phdc_pkg::DP_SQRT_INIT: begin
                r_rad  <= r_d2;
                r_rem  <= '0;
                r_root <= '0;
            end
            phdc_pkg::DP_SQRT_STEP: begin
                r_rad <= r_rad << 2;
                if (w_sq_ok) begin
                    r_rem  <= (RW+1)'(w_sq_trial - w_sq_sub);
                    r_root <= {r_root[RW-2:0], 1'b1};
                end else begin
                    r_rem  <= (RW+1)'(w_sq_trial);
                    r_root <= {r_root[RW-2:0], 1'b0};
                end
            end
            phdc_pkg::DP_OVER: begin
                r_factor <= i_cmd.head ? FW'(r_step) : (r_root - FW'(r_spacing));
            end
            phdc_pkg::DP_MUL: begin
                r_prod <= w_pr;
            end
            phdc_pkg::DP_NUM: begin
                r_num  <= NW'({r_prod, 1'b0}) + NW'(r_root);
                r_drem <= '0;
            end
            phdc_pkg::DP_DIV_STEP: begin
                if (w_dv_ok) begin
                    r_drem <= (RW+1)'(w_dv_trial - w_dv_div);
                    r_num  <= {r_num[NW-2:0], 1'b1};
                end else begin
                    r_drem <= (RW+1)'(w_dv_trial);
                    r_num  <= {r_num[NW-2:0], 1'b0};
                end
            end
            phdc_pkg::DP_ADD: begin
                if (i_cmd.axis) begin
                    r_ay <= w_sat;
                end else begin
                    r_ax <= w_sat;
                end
            end
            phdc_pkg::DP_STORE: begin
                r_prx <= r_ax;
                r_pry <= r_ay;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.op == phdc_pkg::DP_EMIT) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == phdc_pkg::DP_EMIT) begin
            o_part_index <= i_part;
            o_pos_x      <= r_ax;
            o_pos_y      <= r_ay;
            o_is_paused  <= r_paused;
            o_last_part  <= i_cmd.last;
        end
    end

    // status to the controller
    assign o_stat.paused    = r_paused;
    assign o_stat.head_move = w_head_move;
    assign o_stat.link_move = w_gt1;
    assign o_stat.out_free  = !o_out_valid || i_out_ready;

endmodule

`default_nettype wire

@@ rtl/phdc_ctrl.sv @@
// phdc_ctrl: sequencer for one tick: head, then each link, each emitted in turn
// uses phdc_pkg; drives phdc_dpath through command and status structs
`timescale 1ns / 1ps
`default_nettype none

module phdc_ctrl #(
    parameter int NUM_LINKS  = 13,
    parameter int SQRT_STEPS = 17,
    parameter int DIV_STEPS  = 36,
    parameter int AW         = 4
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_in_valid,
    output logic                          o_in_ready,
    input  wire phdc_pkg::t_dp_stat       i_stat,
    output phdc_pkg::t_dp_cmd             o_cmd,
    output logic [AW-1:0]                 o_link_addr,
    output logic [phdc_pkg::PART_W-1:0]   o_part
);

    localparam int CW = $clog2(NUM_LINKS + 1);
    localparam int MAXS = (SQRT_STEPS > DIV_STEPS) ? SQRT_STEPS : DIV_STEPS;
    localparam int KW = $clog2(MAXS + 1);

    phdc_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_part, n_part;
    logic [KW-1:0]    r_cnt, n_cnt;
    logic             r_axis, n_axis;
    logic             w_head, w_last, w_move;

    assign w_head = r_part == '0;
    assign w_last = r_part == CW'(NUM_LINKS);
    assign w_move = w_head ? i_stat.head_move : i_stat.link_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= phdc_pkg::S_IDLE;
            r_part  <= '0;
            r_cnt   <= '0;
            r_axis  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_part  <= n_part;
            r_cnt   <= n_cnt;
            r_axis  <= n_axis;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_part  = r_part;
        n_cnt   = r_cnt;
        n_axis  = r_axis;
        unique case (r_state)
            phdc_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = phdc_pkg::S_HEAD;
                    n_part  = '0;
                end
            end
            phdc_pkg::S_HEAD:
                n_state = i_stat.paused ? phdc_pkg::S_STORE : phdc_pkg::S_DIFF;
            phdc_pkg::S_RD:   n_state = phdc_pkg::S_LOAD;
            phdc_pkg::S_LOAD:
                n_state = i_stat.paused ? phdc_pkg::S_STORE : phdc_pkg::S_DIFF;
            phdc_pkg::S_DIFF: n_state = phdc_pkg::S_SQX;
            phdc_pkg::S_SQX:  n_state = phdc_pkg::S_SQY;
            phdc_pkg::S_SQY:  n_state = phdc_pkg::S_SUM;
            phdc_pkg::S_SUM:  n_state = phdc_pkg::S_CMP;
            phdc_pkg::S_CMP:
                n_state = w_move ? phdc_pkg::S_SQRT_INIT : phdc_pkg::S_STORE;
            phdc_pkg::S_SQRT_INIT: begin
                n_state = phdc_pkg::S_SQRT;
                n_cnt   = '0;
            end
            phdc_pkg::S_SQRT: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == KW'(SQRT_STEPS - 1)) begin
                    n_state = phdc_pkg::S_OVER;
                end
            end
            phdc_pkg::S_OVER: begin
                n_state = phdc_pkg::S_MUL;
                n_axis  = 1'b0;
            end
            phdc_pkg::S_MUL:  n_state = phdc_pkg::S_NUM;
            phdc_pkg::S_NUM: begin
                n_state = phdc_pkg::S_DIV;
                n_cnt   = '0;
            end
            phdc_pkg::S_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == KW'(DIV_STEPS - 1)) begin
                    n_state = phdc_pkg::S_ADD;
                end
            end
            phdc_pkg::S_ADD: begin
                if (r_axis) begin
                    n_state = phdc_pkg::S_STORE;
                end else begin
                    n_state = phdc_pkg::S_MUL;
                    n_axis  = 1'b1;
                end
            end
            phdc_pkg::S_STORE: n_state = phdc_pkg::S_EMIT;
            phdc_pkg::S_EMIT: begin
                if (i_stat.out_free) begin
                    if (w_last) begin
                        n_state = phdc_pkg::S_IDLE;
                    end else begin
                        n_state = phdc_pkg::S_RD;
                        n_part  = r_part + 1'b1;
                    end
                end
            end
            default: n_state = phdc_pkg::S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_in_ready  = 1'b0;
        o_cmd.op    = phdc_pkg::DP_NOP;
        o_cmd.axis  = r_axis;
        o_cmd.head  = w_head;
        o_cmd.last  = w_last;
        unique case (r_state)
            phdc_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = phdc_pkg::DP_ACCEPT;
                end
            end
            phdc_pkg::S_HEAD:      o_cmd.op = phdc_pkg::DP_LOAD_HEAD;
            phdc_pkg::S_RD:        o_cmd.op = phdc_pkg::DP_MEM_RD;
            phdc_pkg::S_LOAD:      o_cmd.op = phdc_pkg::DP_LOAD_LINK;
            phdc_pkg::S_DIFF:      o_cmd.op = phdc_pkg::DP_DIFF;
            phdc_pkg::S_SQX: begin
                o_cmd.op   = phdc_pkg::DP_SQ;
                o_cmd.axis = 1'b0;
            end
            phdc_pkg::S_SQY: begin
                o_cmd.op   = phdc_pkg::DP_SQ;
                o_cmd.axis = 1'b1;
            end
            phdc_pkg::S_SUM:       o_cmd.op = phdc_pkg::DP_SUM;
            phdc_pkg::S_CMP:       o_cmd.op = w_head ? phdc_pkg::DP_HALT : phdc_pkg::DP_NOP;
            phdc_pkg::S_SQRT_INIT: o_cmd.op = phdc_pkg::DP_SQRT_INIT;
            phdc_pkg::S_SQRT:      o_cmd.op = phdc_pkg::DP_SQRT_STEP;
            phdc_pkg::S_OVER:      o_cmd.op = phdc_pkg::DP_OVER;
            phdc_pkg::S_MUL:       o_cmd.op = phdc_pkg::DP_MUL;
            phdc_pkg::S_NUM:       o_cmd.op = phdc_pkg::DP_NUM;
            phdc_pkg::S_DIV:       o_cmd.op = phdc_pkg::DP_DIV_STEP;
            phdc_pkg::S_ADD:       o_cmd.op = phdc_pkg::DP_ADD;
            phdc_pkg::S_STORE:     o_cmd.op = phdc_pkg::DP_STORE;
            phdc_pkg::S_EMIT:      o_cmd.op = i_stat.out_free ? phdc_pkg::DP_EMIT
                                                              : phdc_pkg::DP_NOP;
            default: ;
        endcase
    end

    assign o_link_addr = AW'(r_part - 1'b1);
    assign o_part      = phdc_pkg::PART_W'(r_part);

endmodule

`default_nettype wire
